FILE: hdl/sensor_spi_frame_checker_macros.svh
// assertion macros shared by the frame checker verification code
`ifndef SENSOR_SPI_FRAME_CHECKER_MACROS_SVH
`define SENSOR_SPI_FRAME_CHECKER_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define SSCF_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("frame checker assertion failed");

// expression must never be true outside reset
`define SSCF_ASSERT_NEVER(label, expr) \
  `SSCF_ASSERT(label, !(expr))

`endif

FILE: hdl/sscf_pkg.sv
// shared types, constants and crc helpers for the spi frame checker
package sscf_pkg;

  // field widths
  localparam int FRAME_W  = 32;
  localparam int ADDR_W   = 5;
  localparam int STATUS_W = 2;
  localparam int DATA_W   = 16;
  localparam int ACCEL_W  = 22;
  localparam int TEMP_W   = 21;
  localparam int MODE_W   = 2;

  // measurement mode codes
  typedef enum logic [MODE_W-1:0] {
    MODE_1 = 2'd0,
    MODE_2 = 2'd1,
    MODE_3 = 2'd2,
    MODE_4 = 2'd3
  } mode_e;

  localparam mode_e MODE_RESET = MODE_1;

  // return status code for a good response
  localparam logic [STATUS_W-1:0] STATUS_OK = 2'b01;

  // crc-8 definition
  localparam logic [7:0] CRC_POLY = 8'h1D;
  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam int         CRC_DATA_W = 24;

  // sensitivity is 675 times a power of two, so 65536/S = 2^k / 675
  localparam int ACCEL_MAG_W = 30;
  localparam int ACCEL_Q_W   = 21;
  localparam int ACCEL_RSH   = 41;
  localparam logic [31:0] ACCEL_RECIP = 32'd3257812231; // ceil(2^41 / 675)
  localparam int SHIFT_W = 4;
  localparam logic [SHIFT_W-1:0] SHIFT_MODE_1 = 4'd14;  // S = 2700
  localparam logic [SHIFT_W-1:0] SHIFT_MODE_2 = 4'd15;  // S = 1350
  localparam logic [SHIFT_W-1:0] SHIFT_MODE_HI = 4'd13; // S = 5400

  // temperature: floor(u * 2560 / 189) through one reciprocal multiply
  localparam int TEMP_RSH   = 24;
  localparam int TEMP_Q_W   = 20;
  localparam logic [27:0] TEMP_RECIP = 28'd227246947;   // ceil(2560 * 2^24 / 189)
  localparam logic signed [TEMP_W-1:0] TEMP_OFFSET = 21'sd69888;

  // bit-serial crc, only evaluated on constants to build the xor matrix
  function automatic logic [7:0] crc_raw(logic [CRC_DATA_W-1:0] data);
    logic [7:0] c;
    logic       top;
    c = CRC_INIT;
    for (int i = CRC_DATA_W - 1; i >= 0; i--) begin
      top = c[7] ^ data[i];
      c   = {c[6:0], 1'b0};
      if (top) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  // contribution of each data bit to the crc register
  function automatic logic [CRC_DATA_W-1:0][7:0] crc_cols();
    logic [CRC_DATA_W-1:0][7:0] cols;
    for (int i = 0; i < CRC_DATA_W; i++) begin
      cols[i] = crc_raw(CRC_DATA_W'(1) << i) ^ crc_raw('0);
    end
    return cols;
  endfunction

  localparam logic [7:0]                 CRC_BASE = crc_raw('0);
  localparam logic [CRC_DATA_W-1:0][7:0] CRC_COL  = crc_cols();

endpackage

FILE: hdl/sscf_crc_check.sv
// crc-8 check of one response frame as a parallel xor network
module sscf_crc_check
  import sscf_pkg::*;
(
  input  logic [FRAME_W-1:0] frame_i,
  output logic               crc_ok_o
);

  logic [7:0] crc;

  // xor in the column of every set data bit
  always_comb begin
    crc = CRC_BASE;
    for (int i = 0; i < CRC_DATA_W; i++) begin
      if (frame_i[i+8]) crc = crc ^ CRC_COL[i];
    end
  end

  assign crc_ok_o = ((~crc) == frame_i[7:0]);

endmodule

FILE: hdl/sscf_scale.sv
// acceleration and temperature scaling by reciprocal multiplication
module sscf_scale
  import sscf_pkg::*;
(
  input  logic [DATA_W-1:0]        data_i,
  input  mode_e                    mode_i,
  output logic signed [ACCEL_W-1:0] accel_o,
  output logic signed [TEMP_W-1:0]  temp_o
);

  logic [SHIFT_W-1:0]       shamt;
  logic signed [30:0]       num;
  logic                     neg;
  logic [ACCEL_MAG_W-1:0]   mag;
  logic [61:0]              accel_prod;
  logic [ACCEL_Q_W-1:0]     accel_q;
  logic [43:0]              temp_prod;
  logic [TEMP_Q_W-1:0]      temp_q;

  // power of two that goes with the mode sensitivity
  always_comb begin
    case (mode_i)
      MODE_1:  shamt = SHIFT_MODE_1;
      MODE_2:  shamt = SHIFT_MODE_2;
      default: shamt = SHIFT_MODE_HI;
    endcase
  end

  // floor division of a negative value via one's complement
  assign num = 31'(signed'(data_i)) <<< shamt;
  assign neg = num[30];
  assign mag = neg ? ~num[ACCEL_MAG_W-1:0] : num[ACCEL_MAG_W-1:0];

  assign accel_prod = 62'(mag) * 62'(ACCEL_RECIP);
  assign accel_q    = accel_prod[ACCEL_RSH +: ACCEL_Q_W];
  assign accel_o    = neg ? ~signed'({1'b0, accel_q}) : signed'({1'b0, accel_q});

  // temperature from unsigned data
  assign temp_prod = 44'(data_i) * 44'(TEMP_RECIP);
  assign temp_q    = temp_prod[TEMP_RSH +: TEMP_Q_W];
  assign temp_o    = signed'({1'b0, temp_q}) - TEMP_OFFSET;

endmodule

FILE: hdl/sensor_spi_frame_checker.sv
// top level of the spi response frame checker
// a taken frame goes through the input register, then the result register raises its result strobe
// throughput: one frame per cycle, set by the input and result registers
// busy_o stays low; the result is shown for one cycle and cannot be held off
// reset clears the valid flags and sets measurement mode 1
// the mode register changes only at a clock edge with cfg_we_i high
module sensor_spi_frame_checker
  import sscf_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [MODE_W-1:0]         cfg_wdata_i,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [FRAME_W-1:0]        response_frame_i,
  output logic                      result_valid_o,
  output logic                      write_flag_o,
  output logic [ADDR_W-1:0]         register_address_o,
  output logic [STATUS_W-1:0]       return_status_o,
  output logic                      status_ok_o,
  output logic                      crc_ok_o,
  output logic signed [DATA_W-1:0]  data_raw_o,
  output logic signed [ACCEL_W-1:0] accel_scaled_o,
  output logic signed [TEMP_W-1:0]  temp_scaled_o
);

  mode_e                    mode_q;
  logic                     in_valid_q;
  logic [FRAME_W-1:0]       frame_q;
  logic                     crc_ok_d;
  logic signed [ACCEL_W-1:0] accel_d;
  logic signed [TEMP_W-1:0]  temp_d;
  logic                     out_valid_q;
  logic                     write_flag_q;
  logic [ADDR_W-1:0]        addr_q;
  logic [STATUS_W-1:0]      status_q;
  logic                     status_ok_q;
  logic                     crc_ok_q;
  logic signed [DATA_W-1:0] data_q;
  logic signed [ACCEL_W-1:0] accel_q;
  logic signed [TEMP_W-1:0]  temp_q;

  assign busy_o = 1'b0;

  // measurement mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_RESET;
    end else if (cfg_we_i) begin
      mode_q <= mode_e'(cfg_wdata_i);
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      frame_q <= response_frame_i;
    end
  end

  sscf_crc_check u_crc (
    .frame_i  (frame_q),
    .crc_ok_o (crc_ok_d)
  );

  sscf_scale u_scale (
    .data_i  (frame_q[23:8]),
    .mode_i  (mode_q),
    .accel_o (accel_d),
    .temp_o  (temp_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      write_flag_q <= frame_q[31];
      addr_q       <= frame_q[30:26];
      status_q     <= frame_q[25:24];
      status_ok_q  <= (frame_q[25:24] == STATUS_OK);
      crc_ok_q     <= crc_ok_d;
      data_q       <= signed'(frame_q[23:8]);
      accel_q      <= accel_d;
      temp_q       <= temp_d;
    end
  end

  assign result_valid_o     = out_valid_q;
  assign write_flag_o       = write_flag_q;
  assign register_address_o = addr_q;
  assign return_status_o    = status_q;
  assign status_ok_o        = status_ok_q;
  assign crc_ok_o           = crc_ok_q;
  assign data_raw_o         = data_q;
  assign accel_scaled_o     = accel_q;
  assign temp_scaled_o      = temp_q;

endmodule

FILE: hdl/sscf_checker.sv
// port-level checker for the spi frame checker, bound to the top level
`include "sensor_spi_frame_checker_macros.svh"

module sscf_checker
  import sscf_pkg::*;
(
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start_i,
  input logic                      busy_o,
  input logic [FRAME_W-1:0]        response_frame_i,
  input logic                      result_valid_o,
  input logic                      write_flag_o,
  input logic [ADDR_W-1:0]         register_address_o,
  input logic [STATUS_W-1:0]       return_status_o,
  input logic                      status_ok_o,
  input logic signed [DATA_W-1:0]  data_raw_o,
  input logic signed [ACCEL_W-1:0] accel_scaled_o
);

  // every accepted transaction gives exactly one strobe, after the input and result registers
  `SSCF_ASSERT(a_result_follows, (start_i && !busy_o) |-> ##2 result_valid_o)
  `SSCF_ASSERT(a_no_spurious, (!(start_i && !busy_o)) |-> ##2 !result_valid_o)

  // header and data fields come from the frame that the strobe belongs to
  `SSCF_ASSERT(a_fields_match, result_valid_o |->
    (write_flag_o == $past(response_frame_i[31], 2)) &&
    (register_address_o == $past(response_frame_i[30:26], 2)) &&
    (data_raw_o == signed'($past(response_frame_i[23:8], 2))))

  // status flag agrees with the status field
  `SSCF_ASSERT(a_status_flag, result_valid_o |->
    (status_ok_o == (return_status_o == STATUS_OK)))

  // acceleration keeps the sign of the raw data
  `SSCF_ASSERT_NEVER(a_accel_sign, result_valid_o &&
    (accel_scaled_o[ACCEL_W-1] != data_raw_o[DATA_W-1]))

endmodule

bind sensor_spi_frame_checker sscf_checker u_sscf_checker (.*);

FILE: tb/tb_top.sv
// self-checking testbench for the spi response frame checker
`timescale 1ns / 100ps

module tb_top
  import sscf_pkg::*;
();

  // decoded fields of one checked frame
  typedef struct {
    logic                      write_flag;
    logic [ADDR_W-1:0]         register_address;
    logic [STATUS_W-1:0]       return_status;
    logic                      status_ok;
    logic                      crc_ok;
    logic signed [DATA_W-1:0]  data_raw;
    logic signed [ACCEL_W-1:0] accel_scaled;
    logic signed [TEMP_W-1:0]  temp_scaled;
  } frame_fields_t;

  // one row of the directed stimulus table
  typedef struct {
    logic [FRAME_W-1:0] frame;
    mode_e              mode;
    bit                 typed;
    frame_fields_t      fields;
  } frame_row_t;

  localparam int RANDOM_PHASES    = 8;
  localparam int FRAMES_PER_PHASE = 200;
  localparam int DRAIN_CYCLES     = 4;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [MODE_W-1:0]         cfg_wdata_i;
  logic                      start_i;
  logic                      busy_o;
  logic [FRAME_W-1:0]        response_frame_i;
  logic                      result_valid_o;
  logic                      write_flag_o;
  logic [ADDR_W-1:0]         register_address_o;
  logic [STATUS_W-1:0]       return_status_o;
  logic                      status_ok_o;
  logic                      crc_ok_o;
  logic signed [DATA_W-1:0]  data_raw_o;
  logic signed [ACCEL_W-1:0] accel_scaled_o;
  logic signed [TEMP_W-1:0]  temp_scaled_o;

  frame_fields_t awaited_frame_fields[$];
  frame_row_t    directed_rows[$];
  mode_e         cur_mode;
  int            mismatch_count;
  bit            quiet_stretch;

  sensor_spi_frame_checker dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .response_frame_i   (response_frame_i),
    .result_valid_o     (result_valid_o),
    .write_flag_o       (write_flag_o),
    .register_address_o (register_address_o),
    .return_status_o    (return_status_o),
    .status_ok_o        (status_ok_o),
    .crc_ok_o           (crc_ok_o),
    .data_raw_o         (data_raw_o),
    .accel_scaled_o     (accel_scaled_o),
    .temp_scaled_o      (temp_scaled_o)
  );

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // crc-8 over frame bits 31..8, msb first, inverted at the end
  function automatic logic [7:0] frame_crc8(input logic [23:0] body);
    logic [7:0] c;
    logic       top;
    c = CRC_INIT;
    for (int i = 23; i >= 0; i--) begin
      top = c[7] ^ body[i];
      c   = {c[6:0], 1'b0};
      if (top) c = c ^ CRC_POLY;
    end
    return ~c;
  endfunction

  // expected fields of one frame under the given measurement mode
  function automatic frame_fields_t decode_frame(input logic [FRAME_W-1:0] frame,
                                                 input mode_e mode);
    frame_fields_t f;
    longint        raw;
    longint        u;
    longint        sens;
    longint        num;
    longint        q;
    longint        temp;
    f.write_flag       = frame[31];
    f.register_address = frame[30:26];
    f.return_status    = frame[25:24];
    f.status_ok        = (frame[25:24] == STATUS_OK);
    f.crc_ok           = (frame_crc8(frame[31:8]) == frame[7:0]);
    f.data_raw         = frame[23:8];
    raw = longint'($signed(frame[23:8]));
    u   = longint'(frame[23:8]);
    case (mode)
      MODE_1:  sens = 2700;
      MODE_2:  sens = 1350;
      default: sens = 5400;
    endcase
    // acceleration rounds toward minus infinity
    num = raw * 65536;
    q   = num / sens;
    if ((num % sens) != 0 && num < 0) q = q - 1;
    f.accel_scaled = q[ACCEL_W-1:0];
    temp = (u * 2560) / 189 - 69888;
    f.temp_scaled = temp[TEMP_W-1:0];
    return f;
  endfunction

  // random frame, mostly with a good crc and often a good status
  function automatic logic [FRAME_W-1:0] make_random_frame();
    logic [23:0] body;
    logic [7:0]  crc;
    int          pick;
    body = 24'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      case ($urandom_range(0, 4))
        0:       body[15:0] = 16'h0000;
        1:       body[15:0] = 16'h7FFF;
        2:       body[15:0] = 16'h8000;
        3:       body[15:0] = 16'hFFFF;
        default: body[15:0] = 16'h0001;
      endcase
    end
    if (pick < 50) body[17:16] = STATUS_OK;
    if ($urandom_range(0, 99) < 70) crc = frame_crc8(body);
    else crc = 8'($urandom);
    return {body, crc};
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    mismatch_count++;
  endtask

  task automatic add_row(input logic [FRAME_W-1:0] frame, input mode_e mode,
                         input bit typed, input frame_fields_t fields);
    frame_row_t row;
    row.frame  = frame;
    row.mode   = mode;
    row.typed  = typed;
    row.fields = fields;
    directed_rows.push_back(row);
  endtask

  // present one frame and record what it should give once it is taken
  task automatic send_frame(input logic [FRAME_W-1:0] frame, input bit typed,
                            input frame_fields_t typed_fields);
    start_i          <= 1'b1;
    response_frame_i <= frame;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    if (typed) awaited_frame_fields.push_back(typed_fields);
    else awaited_frame_fields.push_back(decode_frame(frame, cur_mode));
  endtask

  // random idle cycles between frames, about 31 in a hundred, none in a quiet stretch
  task automatic sender_gap();
    while (!quiet_stretch && $urandom_range(0, 99) < 31) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // wait for every result, then write the mode register
  task automatic set_mode(input mode_e mode);
    start_i <= 1'b0;
    @(posedge clk_i);
    while (awaited_frame_fields.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_mode = mode;
  endtask

  // stimulus
  initial begin
    frame_fields_t no_fields;
    frame_fields_t zero_good;
    frame_fields_t zero_bad;
    mode_e         phase_mode[RANDOM_PHASES];

    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = MODE_1;
    start_i          = 1'b0;
    response_frame_i = '0;
    cur_mode         = MODE_RESET;
    mismatch_count   = 0;
    quiet_stretch    = 1'b0;
    phase_mode = '{MODE_2, MODE_4, MODE_1, MODE_3, MODE_4, MODE_2, MODE_1, MODE_3};

    no_fields = '{default: '0};
    // all-zero frame with the crc that 24 zero bits give
    zero_good = '{default: '0};
    zero_good.crc_ok      = 1'b1;
    zero_good.temp_scaled = -21'sd69888;
    zero_bad = zero_good;
    zero_bad.crc_ok = 1'b0;

    // directed table, first rows run on the reset mode
    add_row(32'h000000F1, MODE_1, 1'b1, zero_good);
    add_row(32'h000000F0, MODE_1, 1'b1, zero_bad);
    add_row(32'hFFFFFFFF, MODE_1, 1'b0, no_fields);
    add_row(32'h01000000, MODE_1, 1'b0, no_fields);
    add_row(32'h02000000, MODE_1, 1'b0, no_fields);
    add_row(32'h03000000, MODE_1, 1'b0, no_fields);
    add_row(32'h80000000, MODE_1, 1'b0, no_fields);
    add_row(32'h7C000000, MODE_1, 1'b0, no_fields);
    add_row(32'h007FFF00, MODE_1, 1'b0, no_fields);
    add_row(32'h00800000, MODE_1, 1'b0, no_fields);
    add_row(32'h00FFFF00, MODE_1, 1'b0, no_fields);
    add_row(32'h00000100, MODE_1, 1'b0, no_fields);
    add_row(32'h007FFF00, MODE_2, 1'b0, no_fields);
    add_row(32'h00800000, MODE_2, 1'b0, no_fields);
    add_row(32'h00FFFF00, MODE_2, 1'b0, no_fields);
    add_row(32'h007FFF00, MODE_3, 1'b0, no_fields);
    add_row(32'h00800000, MODE_3, 1'b0, no_fields);
    add_row(32'h00FFFF00, MODE_3, 1'b0, no_fields);
    add_row(32'h00800000, MODE_4, 1'b0, no_fields);
    add_row(32'h007FFF00, MODE_4, 1'b0, no_fields);
    add_row(32'h00FFFF00, MODE_4, 1'b0, no_fields);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    foreach (directed_rows[i]) begin
      if (directed_rows[i].mode != cur_mode) set_mode(directed_rows[i].mode);
      send_frame(directed_rows[i].frame, directed_rows[i].typed, directed_rows[i].fields);
      sender_gap();
    end

    // random part, one mode per phase
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_mode(phase_mode[p]);
      for (int n = 0; n < FRAMES_PER_PHASE; n++) begin
        quiet_stretch = (p == 3);
        send_frame(make_random_frame(), 1'b0, no_fields);
        sender_gap();
      end
    end

    // drain and finish
    start_i <= 1'b0;
    @(posedge clk_i);
    while (awaited_frame_fields.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  // result checker
  always @(posedge clk_i) begin
    frame_fields_t exp;
    if (rst_ni && result_valid_o) begin
      if (awaited_frame_fields.size() == 0) begin
        report_mismatch("result with no frame outstanding");
      end else begin
        exp = awaited_frame_fields.pop_front();
        if (write_flag_o !== exp.write_flag)
          report_mismatch($sformatf("write_flag got %0d want %0d",
                                    write_flag_o, exp.write_flag));
        if (register_address_o !== exp.register_address)
          report_mismatch($sformatf("register_address got %0d want %0d",
                                    register_address_o, exp.register_address));
        if (return_status_o !== exp.return_status)
          report_mismatch($sformatf("return_status got %0d want %0d",
                                    return_status_o, exp.return_status));
        if (status_ok_o !== exp.status_ok)
          report_mismatch($sformatf("status_ok got %0d want %0d",
                                    status_ok_o, exp.status_ok));
        if (crc_ok_o !== exp.crc_ok)
          report_mismatch($sformatf("crc_ok got %0d want %0d", crc_ok_o, exp.crc_ok));
        if (data_raw_o !== exp.data_raw)
          report_mismatch($sformatf("data_raw got %0d want %0d", data_raw_o, exp.data_raw));
        if (accel_scaled_o !== exp.accel_scaled)
          report_mismatch($sformatf("accel_scaled got %0d want %0d",
                                    accel_scaled_o, exp.accel_scaled));
        if (temp_scaled_o !== exp.temp_scaled)
          report_mismatch($sformatf("temp_scaled got %0d want %0d",
                                    temp_scaled_o, exp.temp_scaled));
      end
    end
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: sensor_spi_frame_checker.f
+incdir+hdl
hdl/sscf_pkg.sv
hdl/sscf_crc_check.sv
hdl/sscf_scale.sv
hdl/sensor_spi_frame_checker.sv
hdl/sscf_checker.sv
tb/tb_top.sv
